[rtl/m4ct_pkg.sv]
package m4ct_pkg;

    localparam int ELEM_W    = 32;
    localparam int COL_W     = 2;
    localparam int FRAC_W    = 16;
    localparam int PROD_W    = 2 * ELEM_W;
    localparam int TRUNC_W   = PROD_W - FRAC_W;
    localparam int ACC_W     = TRUNC_W + 3;
    localparam int MAX_LANES = 4;
    localparam int K_W       = $clog2(MAX_LANES);
    localparam int FIELD_W   = COL_W + MAX_LANES * ELEM_W;
    localparam int TDATA_W   = ((FIELD_W + 7) / 8) * 8;

    localparam logic [ELEM_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [ELEM_W-1:0] SAT_MIN = 32'h8000_0000;

    typedef enum logic
    {
        ACT_LOAD  = 1'b0,
        ACT_XFORM = 1'b1
    } action_t;

    typedef enum logic [3:0]
    {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_ACC  = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    typedef struct packed
    {
        logic           capture;
        logic           load;
        logic           mul_en;
        logic           acc_en;
        logic           out_load;
        logic [K_W-1:0] k;
    } cmd_t;

    typedef struct packed
    {
        logic out_free;
    } stat_t;

    typedef struct packed
    {
        logic              ovf;
        logic [ELEM_W-1:0] val;
    } sat_t;

    function automatic sat_t saturate(input logic [ACC_W-1:0] acc);
        sat_t                       s;
        logic [ACC_W-ELEM_W:0]      upper;
        upper = acc[ACC_W-1:ELEM_W-1];
        if ((upper == '0) || (upper == '1))
        begin
            s.ovf = 1'b0;
            s.val = acc[ELEM_W-1:0];
        end
        else
        begin
            s.ovf = 1'b1;
            s.val = acc[ACC_W-1] ? SAT_MIN : SAT_MAX;
        end
        return s;
    endfunction

endpackage

[rtl/m4ct_ctrl.sv]
module m4ct_ctrl #(
    parameter int DIM = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    input  logic            action,
    output logic            s_tready,
    input  m4ct_pkg::stat_t stat,
    output m4ct_pkg::cmd_t  cmd
);

    localparam int LANES = (DIM < 4) ? DIM : 4;

    m4ct_pkg::state_t             state_reg, state_next;
    logic [m4ct_pkg::K_W-1:0]     k_reg, k_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= m4ct_pkg::ST_IDLE;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        k_next       = k_reg;
        s_tready     = 1'b0;
        cmd          = '0;
        cmd.k        = k_reg;
        unique case (state_reg)
            m4ct_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    if (action == m4ct_pkg::ACT_XFORM)
                    begin
                        cmd.capture = 1'b1;
                        k_next      = '0;
                        state_next  = m4ct_pkg::ST_MUL;
                    end
                    else
                    begin
                        cmd.load = 1'b1;
                    end
                end
            end
            m4ct_pkg::ST_MUL:
            begin
                cmd.mul_en = 1'b1;
                cmd.acc_en = (k_reg != '0);
                if (k_reg == m4ct_pkg::K_W'(LANES - 1))
                begin
                    state_next = m4ct_pkg::ST_ACC;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            m4ct_pkg::ST_ACC:
            begin
                cmd.acc_en = 1'b1;
                state_next = m4ct_pkg::ST_DONE;
            end
            m4ct_pkg::ST_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = m4ct_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = m4ct_pkg::ST_IDLE;
            end
        endcase
    end

    // result only moves into the output register when it is free
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> stat.out_free)
        else $error("output load while output register busy");

    // a transform always starts at column zero
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> (state_reg == m4ct_pkg::ST_MUL) && (k_reg == '0))
        else $error("transform did not start at column zero");

    // the multiply walk never runs past the last lane
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mul_en |-> (k_reg <= m4ct_pkg::K_W'(LANES - 1)))
        else $error("column counter out of range");

endmodule

[rtl/m4ct_dp.sv]
module m4ct_dp #(
    parameter int DIM = 4
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [m4ct_pkg::TDATA_W-1:0]   s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [m4ct_pkg::TDATA_W-1:0]   m_tdata,
    output logic                           m_tuser,
    input  m4ct_pkg::cmd_t                 cmd,
    output m4ct_pkg::stat_t                stat
);

    localparam int LANES = (DIM < 4) ? DIM : 4;
    localparam int LK_W  = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int EW    = m4ct_pkg::ELEM_W;

    logic signed [EW-1:0]               elem      [m4ct_pkg::MAX_LANES];
    logic [m4ct_pkg::COL_W-1:0]         col_in;
    logic [EW-1:0]                      mat_reg   [LANES][LANES];
    logic signed [EW-1:0]               b_reg     [LANES];
    logic [m4ct_pkg::COL_W-1:0]         col_reg;
    logic signed [m4ct_pkg::PROD_W-1:0] prod_reg  [LANES];
    logic [m4ct_pkg::ACC_W-1:0]         acc_reg   [LANES];
    logic [EW-1:0]                      res_reg   [m4ct_pkg::MAX_LANES];
    logic [m4ct_pkg::COL_W-1:0]         rcol_reg;
    logic                               ovf_reg;
    logic                               valid_reg;
    m4ct_pkg::sat_t                     sat       [LANES];
    logic [LK_W-1:0]                    k_idx;
    logic                               ovf_any;

    assign col_in = s_tdata[m4ct_pkg::COL_W-1:0];
    assign k_idx  = cmd.k[LK_W-1:0];

    always_comb
    begin
        for (int i = 0; i < m4ct_pkg::MAX_LANES; i++)
        begin
            elem[i] = s_tdata[m4ct_pkg::COL_W + EW*i +: EW];
        end
    end

    // stored matrix, indexed [column][row]
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < LANES; c++)
            begin
                for (int r = 0; r < LANES; r++)
                begin
                    mat_reg[c][r] <= '0;
                end
            end
        end
        else if (cmd.load && ({1'b0, col_in} < 3'(LANES)))
        begin
            for (int r = 0; r < LANES; r++)
            begin
                mat_reg[col_in[LK_W-1:0]][r] <= elem[r];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            for (int r = 0; r < LANES; r++)
            begin
                b_reg[r] <= elem[r];
            end
            col_reg <= col_in;
        end
    end

    // one multiplier per row, walked over the columns
    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            for (int r = 0; r < LANES; r++)
            begin
                prod_reg[r] <= b_reg[k_idx] * $signed(mat_reg[k_idx][r]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int r = 0; r < LANES; r++)
        begin
            if (cmd.capture)
            begin
                acc_reg[r] <= '0;
            end
            else if (cmd.acc_en)
            begin
                acc_reg[r] <= acc_reg[r]
                    + {{(m4ct_pkg::ACC_W - m4ct_pkg::TRUNC_W){prod_reg[r][m4ct_pkg::PROD_W-1]}},
                       prod_reg[r][m4ct_pkg::PROD_W-1:m4ct_pkg::FRAC_W]};
            end
        end
    end

    always_comb
    begin
        ovf_any = 1'b0;
        for (int r = 0; r < LANES; r++)
        begin
            sat[r]  = m4ct_pkg::saturate(acc_reg[r]);
            ovf_any = ovf_any | sat[r].ovf;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            for (int r = 0; r < m4ct_pkg::MAX_LANES; r++)
            begin
                res_reg[r] <= (r < LANES) ? sat[r].val : '0;
            end
            rcol_reg <= col_reg;
            ovf_reg  <= ovf_any;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            valid_reg <= 1'b0;
        end
    end

    assign stat.out_free = !valid_reg || m_tready;
    assign m_tvalid      = valid_reg;
    assign m_tuser       = ovf_reg;

    always_comb
    begin
        m_tdata = '0;
        m_tdata[m4ct_pkg::COL_W-1:0] = rcol_reg;
        for (int r = 0; r < m4ct_pkg::MAX_LANES; r++)
        begin
            m_tdata[m4ct_pkg::COL_W + EW*r +: EW] = res_reg[r];
        end
    end

    // overflow flag only comes with a clipped row
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |->
            (res_reg[0] == m4ct_pkg::SAT_MAX) || (res_reg[0] == m4ct_pkg::SAT_MIN) ||
            (res_reg[1] == m4ct_pkg::SAT_MAX) || (res_reg[1] == m4ct_pkg::SAT_MIN) ||
            (res_reg[2] == m4ct_pkg::SAT_MAX) || (res_reg[2] == m4ct_pkg::SAT_MIN) ||
            (res_reg[3] == m4ct_pkg::SAT_MAX) || (res_reg[3] == m4ct_pkg::SAT_MIN))
        else $error("overflow flag without saturated row");

    // accumulators start from zero for every transform
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> (acc_reg[0] == '0))
        else $error("accumulator not cleared");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> m_tvalid)
        else $error("result lost on output load");

endmodule

[rtl/matrix4_column_transform.sv]
// channel  dir  tdata (low bit up)                                      tuser
// s_*      in   column_index[1:0], elem_0..elem_3 (32 each), zero pad    action
// m_*      out  result_column[1:0], res_0..res_3 (32 each), zero pad     overflow
//
// load request: the stored column is written on acceptance and input ready stays high
// transform request: result registered after the MUL, ACC and DONE states, once the output
//   register is free; one 32x32 multiplier per row is stepped across the stored columns
// input ready only while no transform is in flight
// output register lets a new request be taken while a result waits
// reset clears the stored matrix and all handshake state
module matrix4_column_transform #(
    parameter int DIM = 4
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [m4ct_pkg::TDATA_W-1:0] s_tdata,   // column_index, elem_0..elem_3
    input  logic                         s_tuser,   // action
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [m4ct_pkg::TDATA_W-1:0] m_tdata,   // result_column, res_0..res_3
    output logic                         m_tuser    // overflow
);

    m4ct_pkg::cmd_t  cmd;
    m4ct_pkg::stat_t stat;

    m4ct_ctrl #(
        .DIM (DIM)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .action   (s_tuser),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    m4ct_dp #(
        .DIM (DIM)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule

[tb/matrix4_column_transform_tb.sv]
module matrix4_column_transform_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import m4ct_pkg::*;

    localparam int DIM   = 4;
    localparam int LANES = (DIM < MAX_LANES) ? DIM : MAX_LANES;
    localparam int PAD_W = TDATA_W - FIELD_W;

    localparam logic [ELEM_W-1:0] Q_ONE = 32'h0001_0000;
    localparam logic [ELEM_W-1:0] Q_NEG = 32'hFFFF_FFFF;
    localparam logic [ELEM_W-1:0] Q_LSB = 32'h0000_0001;

    typedef logic [MAX_LANES-1:0][ELEM_W-1:0] column_t;

    typedef struct
    {
        logic [COL_W-1:0] col;
        column_t          res;
        logic             ovf;
    } column_result_t;

    class column_checker;
        logic [ELEM_W-1:0] a_mat [MAX_LANES][MAX_LANES];   // [col][row]
        column_result_t    pending_columns [$];
        int                errors;
        int                loads;
        int                transforms;
        int                saturated;

        function new();
            foreach (a_mat[c, r])
                a_mat[c][r] = '0;
            errors     = 0;
            loads      = 0;
            transforms = 0;
            saturated  = 0;
        endfunction

        function column_result_t predict_column(logic [COL_W-1:0] col, column_t b);
            column_result_t exp;
            longint         acc;
            longint         prod;
            exp.col = col;
            exp.ovf = 1'b0;
            exp.res = '0;
            for (int r = 0; r < LANES; r++)
            begin
                acc = 0;
                for (int k = 0; k < LANES; k++)
                begin
                    prod = longint'($signed(b[k])) * longint'($signed(a_mat[k][r]));
                    acc += prod >>> FRAC_W;
                end
                if (acc > 64'sh0000_0000_7FFF_FFFF)
                begin
                    exp.res[r] = SAT_MAX;
                    exp.ovf    = 1'b1;
                end
                else if (acc < -64'sh0000_0000_8000_0000)
                begin
                    exp.res[r] = SAT_MIN;
                    exp.ovf    = 1'b1;
                end
                else
                    exp.res[r] = acc[ELEM_W-1:0];
            end
            return exp;
        endfunction

        function void note_request(action_t act, logic [COL_W-1:0] col, column_t b);
            if (act == ACT_LOAD)
            begin
                loads++;
                if (col < LANES)
                    for (int r = 0; r < LANES; r++)
                        a_mat[col][r] = b[r];
            end
            else
            begin
                transforms++;
                pending_columns.push_back(predict_column(col, b));
            end
        endfunction

        function void report(string what, logic [ELEM_W-1:0] want, logic [ELEM_W-1:0] got);
            $display("%0t: mismatch on %s, expected %h actual %h", $time, what, want, got);
            errors++;
        endfunction

        function void check_result(logic [COL_W-1:0] col, column_t res, logic ovf);
            column_result_t exp;
            if (pending_columns.size() == 0)
            begin
                $display("%0t: result with nothing pending, column %0d data %h overflow %b",
                         $time, col, res, ovf);
                errors++;
                return;
            end
            exp = pending_columns.pop_front();
            if (exp.ovf)
                saturated++;
            if (col !== exp.col)
                report("result_column", 32'(exp.col), 32'(col));
            for (int r = 0; r < MAX_LANES; r++)
                if (res[r] !== exp.res[r])
                    report($sformatf("res_%0d", r), exp.res[r], res[r]);
            if (ovf !== exp.ovf)
                report("overflow", 32'(exp.ovf), 32'(ovf));
        endfunction

        function int pending();
            return pending_columns.size();
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [TDATA_W-1:0]   s_tdata = '0;    // column_index, elem_0..elem_3, zero pad
    logic                 s_tuser = 1'b0;  // action
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [TDATA_W-1:0]   m_tdata;         // result_column, res_0..res_3, zero pad
    logic                 m_tuser;         // overflow

    int snd_idle_pct = 0;
    int rcv_idle_pct = 0;

    column_checker checker_h = new();

    matrix4_column_transform #(
        .DIM (DIM)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(negedge clk)
        m_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                checker_h.note_request(action_t'(s_tuser), s_tdata[COL_W-1:0],
                                       column_t'(s_tdata[COL_W +: MAX_LANES*ELEM_W]));
            if (m_tvalid && m_tready)
                checker_h.check_result(m_tdata[COL_W-1:0],
                                       column_t'(m_tdata[COL_W +: MAX_LANES*ELEM_W]),
                                       m_tuser);
        end
    end

    initial
    begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic column_t make_column(logic [ELEM_W-1:0] e0, logic [ELEM_W-1:0] e1,
                                            logic [ELEM_W-1:0] e2, logic [ELEM_W-1:0] e3);
        return {e3, e2, e1, e0};
    endfunction

    function automatic logic [ELEM_W-1:0] rand_elem(bit wild);
        logic [ELEM_W-1:0] r;
        r = $urandom;
        if (wild)
        begin
            case ($urandom_range(0, 3))
                0: return r;
                1:
                begin
                    case ($urandom_range(0, 4))
                        0: return SAT_MAX;
                        1: return SAT_MIN;
                        2: return Q_NEG;
                        3: return Q_LSB;
                        default: return '0;
                    endcase
                end
                2:
                begin
                    case (r[1:0])
                        2'd0: return {4{8'h00}};
                        2'd1: return {4{8'h55}};
                        2'd2: return {4{8'haa}};
                        default: return {4{8'hff}};
                    endcase
                end
                default: return {{8{r[23]}}, r[23:0]};
            endcase
        end
        case ($urandom_range(0, 4))
            0: return r[31] ? Q_ONE : (r[30] ? Q_NEG : '0);
            default: return {{14{r[17]}}, r[17:0]};
        endcase
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_column(action_t act, logic [COL_W-1:0] col, column_t b);
        if (snd_idle_pct != 0 && $urandom_range(0, 99) < snd_idle_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {{PAD_W{1'b0}}, b, col};
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    task automatic load_matrix(logic [ELEM_W-1:0] c0, logic [ELEM_W-1:0] c1,
                               logic [ELEM_W-1:0] c2, logic [ELEM_W-1:0] c3);
        send_column(ACT_LOAD, 2'd0, {4{c0}});
        send_column(ACT_LOAD, 2'd1, {4{c1}});
        send_column(ACT_LOAD, 2'd2, {4{c2}});
        send_column(ACT_LOAD, 2'd3, {4{c3}});
    endtask

    task automatic run_directed();
        send_column(ACT_XFORM, 2'd2, make_column(SAT_MAX, SAT_MIN, Q_LSB, Q_NEG));
        // identity
        for (int k = 0; k < MAX_LANES; k++)
            send_column(ACT_LOAD, 2'(k), column_t'(Q_ONE) << (k * ELEM_W));
        send_column(ACT_XFORM, 2'd1, make_column(SAT_MAX, SAT_MIN, Q_ONE, Q_NEG));
        load_matrix(SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX);
        send_column(ACT_XFORM, 2'd3, {4{SAT_MAX}});
        send_column(ACT_XFORM, 2'd0, {4{SAT_MIN}});
        // floor rounding of a negative product
        send_column(ACT_XFORM, 2'd2, make_column(Q_NEG, '0, '0, '0));
        send_column(ACT_XFORM, 2'd1, {4{Q_LSB}});
        load_matrix(SAT_MIN, {4{8'h55}}, {4{8'haa}}, {4{8'hff}});
        send_column(ACT_XFORM, 2'd0, make_column(SAT_MIN, '0, '0, '0));
        send_column(ACT_XFORM, 2'd3, make_column('0, Q_ONE, Q_ONE, Q_ONE));
        send_column(ACT_XFORM, 2'd2, make_column(32'h00FF_00FF, Q_NEG, Q_LSB, SAT_MAX));
    endtask

    task automatic run_random(int count);
        bit               wild;
        action_t          act;
        logic [COL_W-1:0] col;
        column_t          b;
        wild = 1'b0;
        for (int i = 0; i < count; i++)
        begin
            if (i % 16 == 0)
                wild = ($urandom_range(0, 99) < 40);
            act = ($urandom_range(0, 99) < 35) ? ACT_LOAD : ACT_XFORM;
            col = COL_W'($urandom_range(0, 3));
            for (int k = 0; k < MAX_LANES; k++)
                b[k] = rand_elem(wild);
            send_column(act, col, b);
        end
    endtask

    initial
    begin
        int wait_cycles;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        snd_idle_pct = 27;
        rcv_idle_pct = 55;
        run_directed();
        run_random(300);

        snd_idle_pct = 55;
        rcv_idle_pct = 27;
        run_random(300);

        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        run_random(300);

        s_tvalid <= 1'b0;
        wait_cycles = 0;
        while (checker_h.pending() != 0 && wait_cycles < 10000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (20) @(posedge clk);

        if (checker_h.pending() != 0)
            $display("%0t: %0d transform results never arrived", $time, checker_h.pending());
        $display("run covered %0d column loads and %0d transforms (%0d saturated),",
                 checker_h.loads, checker_h.transforms, checker_h.saturated);
        $display("across three sender and receiver stall mixes; %0d mismatches",
                 checker_h.errors);
        if (checker_h.errors == 0 && checker_h.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
